@@ rtl/mhs_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the minhash signature core
// no dependencies
package mhs_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned WIN_BYTES = 8;
    localparam int unsigned HALF_W = WORD_W / 2;
    localparam int unsigned KEEP_W = (WIN_BYTES - 1) * BYTE_W;
    localparam int unsigned CNT_W = 3;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WIN_BYTES - 1);

    localparam logic [WORD_W-1:0] SEED_VALUE  = 64'h0000_0000_1234_5678;
    localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [WORD_W-1:0] XP1 = 64'h9E37_79B1_85EB_CA87;
    localparam logic [WORD_W-1:0] XP2 = 64'hC2B2_AE3D_27D4_EB4F;
    localparam logic [WORD_W-1:0] XP3 = 64'h1656_67B1_9E37_79F9;
    localparam logic [WORD_W-1:0] XP4 = 64'h85EB_CA77_C2B2_AE63;
    localparam logic [WORD_W-1:0] XP5 = 64'h27D4_EB2F_1656_67C5;
    localparam logic [WORD_W-1:0] HASH_INIT = SEED_VALUE + XP5 + WORD_W'(WIN_BYTES);
    localparam logic [WORD_W-1:0] ALL_ONES = '1;

    // sideband that rides along the hash pipeline
    typedef struct packed {
        logic valid;
        logic has_hash;
        logic last;
    } t_side;

    // data handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              has_hash;
        logic              last;
        logic [WORD_W-1:0] hash;
        logic [WORD_W-1:0] fold;
    } t_link;

endpackage

@@ rtl/mhs_mul64.sv @@
`timescale 1ns / 1ps
// two-stage 64x64 multiplier keeping the low 64 bits of the product
// uses mhs_pkg
module mhs_mul64 (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [mhs_pkg::WORD_W-1:0] i_a,
    input  logic [mhs_pkg::WORD_W-1:0] i_b,
    output logic [mhs_pkg::WORD_W-1:0] o_p
);

    logic [mhs_pkg::WORD_W-1:0] r_ll;
    logic [mhs_pkg::HALF_W-1:0] r_cross;
    logic [mhs_pkg::WORD_W-1:0] r_p;
    logic [mhs_pkg::WORD_W-1:0] n_ll;
    logic [mhs_pkg::WORD_W-1:0] n_hl;
    logic [mhs_pkg::WORD_W-1:0] n_lh;

    always_comb begin
        n_ll = {32'd0, i_a[31:0]} * {32'd0, i_b[31:0]};
        n_hl = {32'd0, i_a[63:32]} * {32'd0, i_b[31:0]};
        n_lh = {32'd0, i_a[31:0]} * {32'd0, i_b[63:32]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll    <= n_ll;
            r_cross <= n_hl[31:0] + n_lh[31:0];
            r_p     <= r_ll + {r_cross, 32'd0};
        end
    end

    assign o_p = r_p;

endmodule

@@ rtl/mhs_hash.sv @@
`timescale 1ns / 1ps
// pipelined xxh64 of one 8-byte window, sideband carried alongside
// uses mhs_pkg and mhs_mul64
module mhs_hash (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  mhs_pkg::t_side             i_side,
    input  logic [mhs_pkg::WORD_W-1:0] i_window,
    output mhs_pkg::t_side             o_side,
    output logic [mhs_pkg::WORD_W-1:0] o_hash
);

    localparam int unsigned DEPTH = 12;

    mhs_pkg::t_side             r_side [DEPTH];
    logic [mhs_pkg::WORD_W-1:0] m1_p, m2_p, m3_p, m4_p, m5_p;
    logic [mhs_pkg::WORD_W-1:0] m2_a, m3_a, m4_a, m5_a;
    logic [mhs_pkg::WORD_W-1:0] h_mix;
    logic [mhs_pkg::WORD_W-1:0] r_h4;
    logic [mhs_pkg::WORD_W-1:0] r_hash;

    always_comb begin
        m2_a  = {m1_p[32:0], m1_p[63:33]};
        h_mix = mhs_pkg::HASH_INIT ^ m2_p;
        m3_a  = {h_mix[36:0], h_mix[63:37]};
        m4_a  = r_h4 ^ (r_h4 >> 33);
        m5_a  = m4_p ^ (m4_p >> 29);
    end

    mhs_mul64 u_m1 (.i_clk(i_clk), .i_en(i_en), .i_a(i_window), .i_b(mhs_pkg::XP2), .o_p(m1_p));
    mhs_mul64 u_m2 (.i_clk(i_clk), .i_en(i_en), .i_a(m2_a), .i_b(mhs_pkg::XP1), .o_p(m2_p));
    mhs_mul64 u_m3 (.i_clk(i_clk), .i_en(i_en), .i_a(m3_a), .i_b(mhs_pkg::XP1), .o_p(m3_p));
    mhs_mul64 u_m4 (.i_clk(i_clk), .i_en(i_en), .i_a(m4_a), .i_b(mhs_pkg::XP2), .o_p(m4_p));
    mhs_mul64 u_m5 (.i_clk(i_clk), .i_en(i_en), .i_a(m5_a), .i_b(mhs_pkg::XP3), .o_p(m5_p));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h4   <= m3_p + mhs_pkg::XP4;
            r_hash <= m5_p ^ (m5_p >> 32);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DEPTH; s++) begin
                r_side[s] <= '0;
            end
        end else if (i_en) begin
            r_side[0] <= i_side;
            for (int s = 1; s < DEPTH; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    assign o_side = r_side[DEPTH-1];
    assign o_hash = r_hash;

endmodule

@@ rtl/mhs_cell.sv @@
`timescale 1ns / 1ps
// one minimum cell: lowers its permuted minimum, folds it out on the last item
// uses mhs_pkg
module mhs_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic [mhs_pkg::WORD_W-1:0] i_perm,
    input  mhs_pkg::t_link             i_link,
    output mhs_pkg::t_link             o_link
);

    logic [mhs_pkg::WORD_W-1:0] r_min;
    mhs_pkg::t_link             r_link;
    logic [mhs_pkg::WORD_W-1:0] n_perm;
    logic [mhs_pkg::WORD_W-1:0] n_min;
    mhs_pkg::t_link             n_link;

    always_comb begin
        n_perm = i_link.hash ^ i_perm;
        n_min  = (i_link.has_hash && (n_perm < r_min)) ? n_perm : r_min;
        n_link = i_link;
        if (i_link.last) begin
            n_link.fold = i_link.fold ^ n_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min        <= mhs_pkg::ALL_ONES;
            r_link.valid <= 1'b0;
        end else if (i_en) begin
            r_link.valid <= i_link.valid;
            if (i_link.valid) begin
                r_min <= i_link.last ? mhs_pkg::ALL_ONES : n_min;
            end
        end
        if (i_en) begin
            r_link.has_hash <= n_link.has_hash;
            r_link.last     <= n_link.last;
            r_link.hash     <= n_link.hash;
            r_link.fold     <= n_link.fold;
        end
    end

    assign o_link = r_link;

endmodule

@@ rtl/minhash_sliding_window_signature_core.sv @@
`timescale 1ns / 1ps
// top level of the minhash sliding-window signature core
// uses mhs_pkg, mhs_hash, mhs_cell
//
//  channel | valid       | stall        | payload
//  in      | i_in_valid  | o_in_stall   | i_byte_value, i_last_byte
//  out     | o_out_valid | i_out_stall  | o_signature
//
// one byte per cycle while the input is not stalled; the last byte's signature passes through
// the 12-stage hash pipeline, one register per min cell and one output register
// synchronous reset clears the window, the byte count and all minimums to all ones
// a waiting signature under stall freezes the whole pipeline and stalls the input
module minhash_sliding_window_signature_core #(
    parameter int unsigned HASH_COUNT = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [mhs_pkg::BYTE_W-1:0] i_byte_value,
    input  logic                       i_last_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [mhs_pkg::WORD_W-1:0] o_signature
);

    logic                        adv;
    logic                        accept;
    logic [mhs_pkg::KEEP_W-1:0]  r_window;
    logic [mhs_pkg::CNT_W-1:0]   r_count;
    logic [mhs_pkg::WORD_W-1:0]  n_win;
    mhs_pkg::t_side              n_side;
    mhs_pkg::t_side              h_side;
    logic [mhs_pkg::WORD_W-1:0]  h_hash;
    mhs_pkg::t_link              link [HASH_COUNT+1];
    logic                        r_out_valid;
    logic [mhs_pkg::WORD_W-1:0]  r_signature;

    assign adv        = !(r_out_valid && i_out_stall);
    assign o_in_stall = !adv;
    assign accept     = i_in_valid && adv;

    always_comb begin
        n_win           = {i_byte_value, r_window};
        n_side.valid    = accept;
        n_side.has_hash = (r_count == mhs_pkg::CNT_FULL);
        n_side.last     = i_last_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_count  <= '0;
        end else if (accept) begin
            if (i_last_byte) begin
                r_window <= '0;
                r_count  <= '0;
            end else begin
                r_window <= n_win[mhs_pkg::WORD_W-1:mhs_pkg::BYTE_W];
                if (r_count != mhs_pkg::CNT_FULL) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    mhs_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_side  (n_side),
        .i_window(n_win),
        .o_side  (h_side),
        .o_hash  (h_hash)
    );

    always_comb begin
        link[0].valid    = h_side.valid;
        link[0].has_hash = h_side.has_hash;
        link[0].last     = h_side.last;
        link[0].hash     = h_hash;
        link[0].fold     = '0;
    end

    for (genvar g = 0; g < HASH_COUNT; g++) begin : g_cell
        localparam logic [mhs_pkg::WORD_W-1:0] PERM =
            mhs_pkg::WORD_W'(g) * mhs_pkg::GOLDEN_STEP;
        mhs_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (adv),
            .i_perm (PERM),
            .i_link (link[g]),
            .o_link (link[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= link[HASH_COUNT].valid && link[HASH_COUNT].last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_signature <= link[HASH_COUNT].fold;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_signature = r_signature;

endmodule

@@ tb/minhash_sliding_window_signature_core_tb.sv @@
`timescale 1ns / 1ps
// testbench for minhash_sliding_window_signature_core: byte messages in, signatures checked
// against a predictor of the xxh64 window hash and minimum fold; uses mhs_pkg
module minhash_sliding_window_signature_core_tb;

    localparam int unsigned HASH_COUNT = 64;
    localparam int unsigned N_BYTES = 1950;
    localparam int unsigned CALM_AFTER = 1650;
    localparam int unsigned DRAIN_CYCLES = 13 + HASH_COUNT + 16;
    localparam int unsigned QUIET_LIMIT = 4000;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES,
        FILL_ALT
    } t_fill;

    // running minhash predictor and queue of signatures still owed by the block
    class t_sig_tracker;
        logic [mhs_pkg::KEEP_W-1:0] window;
        logic [mhs_pkg::CNT_W-1:0]  seen;
        logic [mhs_pkg::WORD_W-1:0] mins [HASH_COUNT];
        logic [mhs_pkg::WORD_W-1:0] expected_sigs [$];
        int                         fails;

        function new();
            fails = 0;
            clear_state();
        endfunction

        function void clear_state();
            window = '0;
            seen = '0;
            foreach (mins[j]) mins[j] = '1;
        endfunction

        function logic [mhs_pkg::WORD_W-1:0] xxh64_of_window(
            logic [mhs_pkg::WORD_W-1:0] w);
            logic [mhs_pkg::WORD_W-1:0] h;
            logic [mhs_pkg::WORD_W-1:0] k;
            h = mhs_pkg::SEED_VALUE + mhs_pkg::XP5 + mhs_pkg::WORD_W'(mhs_pkg::WIN_BYTES);
            k = w * mhs_pkg::XP2;
            k = {k[32:0], k[63:33]} * mhs_pkg::XP1;
            h = h ^ k;
            h = {h[36:0], h[63:37]} * mhs_pkg::XP1 + mhs_pkg::XP4;
            h = h ^ (h >> 33);
            h = h * mhs_pkg::XP2;
            h = h ^ (h >> 29);
            h = h * mhs_pkg::XP3;
            h = h ^ (h >> 32);
            return h;
        endfunction

        function void note_byte(logic [mhs_pkg::BYTE_W-1:0] b, logic last);
            logic [mhs_pkg::WORD_W-1:0] win;
            logic [mhs_pkg::WORD_W-1:0] h;
            logic [mhs_pkg::WORD_W-1:0] ph;
            logic [mhs_pkg::WORD_W-1:0] fold;
            win = {b, window};
            if (seen == mhs_pkg::CNT_FULL) begin
                h = xxh64_of_window(win);
                for (int j = 0; j < HASH_COUNT; j++) begin
                    ph = h ^ (mhs_pkg::WORD_W'(j) * mhs_pkg::GOLDEN_STEP);
                    if (ph < mins[j]) mins[j] = ph;
                end
            end else begin
                seen = seen + 1'b1;
            end
            window = win[mhs_pkg::WORD_W-1:mhs_pkg::BYTE_W];
            if (last) begin
                fold = '0;
                foreach (mins[j]) fold = fold ^ mins[j];
                expected_sigs.insert(expected_sigs.size(), fold);
                clear_state();
            end
        endfunction

        function void check_signature(logic [mhs_pkg::WORD_W-1:0] actual);
            logic [mhs_pkg::WORD_W-1:0] want;
            if (expected_sigs.size() == 0) begin
                $error("signature: expected none, actual %h", actual);
                fails++;
            end else begin
                want = expected_sigs.pop_front();
                if (actual !== want) begin
                    $error("signature: expected %h, actual %h", want, actual);
                    fails++;
                end
            end
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [mhs_pkg::BYTE_W-1:0] i_byte_value;
    logic                       i_last_byte;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic [mhs_pkg::WORD_W-1:0] o_signature;

    t_sig_tracker sb = new();
    int           bytes_sent;
    int           quiet_cycles;
    int           in_gap_pct;
    int           out_stall_pct;
    bit           calm;

    minhash_sliding_window_signature_core #(
        .HASH_COUNT(HASH_COUNT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_byte_value(i_byte_value),
        .i_last_byte (i_last_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_signature (o_signature)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            sb.note_byte(i_byte_value, i_last_byte);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_signature(o_signature);
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // output stall bursts
    initial begin
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 99) < out_stall_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_byte(input logic [mhs_pkg::BYTE_W-1:0] b, input logic last);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_byte_value <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
        if (bytes_sent >= CALM_AFTER) calm = 1'b1;
    endtask

    task automatic send_message(input int len, input t_fill fill);
        logic [mhs_pkg::BYTE_W-1:0] b;
        case ($urandom_range(0, 2))
            0: in_gap_pct = 0;
            1: in_gap_pct = 8;
            default: in_gap_pct = 35;
        endcase
        case ($urandom_range(0, 2))
            0: out_stall_pct = 0;
            1: out_stall_pct = 8;
            default: out_stall_pct = 35;
        endcase
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_ZERO: b = '0;
                FILL_ONES: b = '1;
                FILL_ALT:  b = i[0] ? '1 : '0;
                default:   b = mhs_pkg::BYTE_W'($urandom);
            endcase
            send_byte(b, i == len - 1);
        end
    endtask

    initial begin
        int len;
        int pick;
        t_fill fill;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_byte_value = '0;
        i_last_byte = 1'b0;
        i_out_stall = 1'b0;
        calm = 1'b0;
        bytes_sent = 0;
        quiet_cycles = 0;
        in_gap_pct = 0;
        out_stall_pct = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_message(1, FILL_ONES);
        send_message(7, FILL_ZERO);
        send_message(8, FILL_ONES);
        send_message(9, FILL_ALT);

        while (bytes_sent < N_BYTES) begin
            pick = $urandom_range(0, 15);
            if (pick < 2) len = $urandom_range(1, 7);
            else if (pick == 2) len = $urandom_range(40, 120);
            else len = $urandom_range(8, 30);
            pick = $urandom_range(0, 19);
            if (pick == 0) fill = FILL_ZERO;
            else if (pick == 1) fill = FILL_ONES;
            else if (pick == 2) fill = FILL_ALT;
            else fill = FILL_RANDOM;
            send_message(len, fill);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.expected_sigs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.fails == 0 && sb.expected_sigs.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
